/* rtl/rdst_pkg.sv */
// ----------------------------------------------------------------------------
// rdst_pkg
// types, widths and helpers shared by the range digit-sum total block
// ----------------------------------------------------------------------------
package rdst_pkg;

   localparam int BinW   = 54;
   localparam int TotW   = 60;
   localparam int CntW   = 6;
   localparam int TightW = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic conv;
      logic walk;
   } cell_ctrl_type;

   function automatic logic [63:0] pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

   // d*(d-1)/2 for one decimal digit
   function automatic logic [5:0] tri_sum(input logic [3:0] d);
      logic [5:0] r;
      unique case (d)
         4'd2:    r = 6'd1;
         4'd3:    r = 6'd3;
         4'd4:    r = 6'd6;
         4'd5:    r = 6'd10;
         4'd6:    r = 6'd15;
         4'd7:    r = 6'd21;
         4'd8:    r = 6'd28;
         4'd9:    r = 6'd36;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/rdst_ifs.sv */
// ----------------------------------------------------------------------------
// rdst channel interfaces
// query and result channels with valid/ready transfer
// ----------------------------------------------------------------------------
interface rdst_req_if;
   logic                    valid;
   logic                    ready;
   logic [rdst_pkg::BinW-1:0] lower_bound;
   logic [rdst_pkg::BinW-1:0] upper_bound;
   modport source (output valid, lower_bound, upper_bound, input ready);
   modport sink   (input valid, lower_bound, upper_bound, output ready);
endinterface

interface rdst_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [rdst_pkg::TotW-1:0] digit_sum_total;
   logic                    range_error;
   modport source (output valid, digit_sum_total, range_error, input ready);
   modport sink   (input valid, digit_sum_total, range_error, output ready);
endinterface

/* rtl/rdst_bcd_cell.sv */
// ----------------------------------------------------------------------------
// rdst_bcd_cell
// one decimal digit of the conversion chain; shifts digits upward when walking
// ----------------------------------------------------------------------------
module rdst_bcd_cell (
   input  logic                    clock,
   input  rdst_pkg::cell_ctrl_type ctrl,
   input  logic                    bit_in,
   input  logic [3:0]              digit_in,
   output logic                    bit_out,
   output logic [3:0]              digit_out
);
   import rdst_pkg::*;

   logic [3:0] digit_ff;
   logic [3:0] digit_in_next;
   logic [3:0] adj;

   assign adj       = (digit_ff >= 4'd5) ? 4'(digit_ff + 4'd3) : digit_ff;
   assign bit_out   = adj[3];
   assign digit_out = digit_ff;

   always_comb begin
      priority if (ctrl.clear) begin
         digit_in_next = 4'd0;
      end else if (ctrl.conv) begin
         digit_in_next = {adj[2:0], bit_in};
      end else if (ctrl.walk) begin
         digit_in_next = digit_in;
      end else begin
         digit_in_next = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

/* rtl/rdst_digit_dp.sv */
// ----------------------------------------------------------------------------
// rdst_digit_dp
// digit dp over one bound, one decimal digit per cycle, most significant first
// ----------------------------------------------------------------------------
module rdst_digit_dp (
   input  logic                    clock,
   input  rdst_pkg::cell_ctrl_type ctrl,
   input  logic [3:0]              digit,
   output logic [rdst_pkg::TotW-1:0] total
);
   import rdst_pkg::*;

   logic [BinW-1:0]   f_cnt_ff,  f_cnt_in;
   logic [TotW-1:0]   f_tot_ff,  f_tot_in;
   logic [TightW-1:0] t_tot_ff,  t_tot_in;
   logic [TotW-1:0]   step_tot;

   assign step_tot = TotW'(f_tot_ff * TotW'(10)) + TotW'(f_cnt_ff * TotW'(45))
                   + TotW'(digit * t_tot_ff) + TotW'(tri_sum(digit));
   assign total    = f_tot_ff + TotW'(t_tot_ff);

   always_comb begin
      priority if (ctrl.clear) begin
         f_cnt_in = '0;
         f_tot_in = '0;
         t_tot_in = '0;
      end else if (ctrl.walk) begin
         f_cnt_in = BinW'(f_cnt_ff * BinW'(10)) + BinW'(digit);
         f_tot_in = step_tot;
         t_tot_in = t_tot_ff + TightW'(digit);
      end else begin
         f_cnt_in = f_cnt_ff;
         f_tot_in = f_tot_ff;
         t_tot_in = t_tot_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_cnt_ff <= f_cnt_in;
      f_tot_ff <= f_tot_in;
      t_tot_ff <= t_tot_in;
   end

endmodule

/* rtl/range_digit_sum_total.sv */
// ----------------------------------------------------------------------------
// range_digit_sum_total
// total of decimal digit sums over lower..upper as S(upper) - S(lower-1)
//
//   channel  dir  fields
//   req      in   lower_bound[53:0], upper_bound[53:0]
//   rsp      out  digit_sum_total[59:0], range_error
//
// one query runs through 54 shift-add-3 steps in the bcd cell chains, then
// one dp step per digit, then the result register
// both bounds run in parallel chains; a new query is taken only when idle
// a stalled result holds in the result register until its transfer
// reset is synchronous and clears the controller and result valid only
// ----------------------------------------------------------------------------
module range_digit_sum_total #(
   parameter int DIGITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   rdst_req_if.sink   req,
   rdst_rsp_if.source rsp
);
   import rdst_pkg::*;

   localparam logic [BinW-1:0] MaxValue = BinW'(pow10(DIGITS) - 64'd1);

   state_type          state_ff, state_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [BinW-1:0]    lo_bin_ff, lo_bin_in, hi_bin_ff, hi_bin_in;
   logic               lo_zero_ff, lo_zero_in, err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_err_ff, rsp_err_in;
   logic [TotW-1:0]    rsp_tot_ff, rsp_tot_in;
   cell_ctrl_type      ctrl;
   logic               accept, load_rsp;
   logic [BinW-1:0]    lo_sat, hi_sat;
   logic [TotW-1:0]    lo_total, hi_total;
   logic [DIGITS:0]    lo_bit, hi_bit;
   logic [3:0]         lo_dig [DIGITS+1];
   logic [3:0]         hi_dig [DIGITS+1];

   assign lo_sat = (req.lower_bound > MaxValue) ? MaxValue : req.lower_bound;
   assign hi_sat = (req.upper_bound > MaxValue) ? MaxValue : req.upper_bound;

   assign lo_bit[0] = lo_bin_ff[BinW-1];
   assign hi_bit[0] = hi_bin_ff[BinW-1];
   assign lo_dig[0] = 4'd0;
   assign hi_dig[0] = 4'd0;

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      rdst_bcd_cell u_lo (
         .clock(clock), .ctrl(ctrl), .bit_in(lo_bit[i]), .digit_in(lo_dig[i]),
         .bit_out(lo_bit[i+1]), .digit_out(lo_dig[i+1])
      );
      rdst_bcd_cell u_hi (
         .clock(clock), .ctrl(ctrl), .bit_in(hi_bit[i]), .digit_in(hi_dig[i]),
         .bit_out(hi_bit[i+1]), .digit_out(hi_dig[i+1])
      );
   end

   rdst_digit_dp u_lo_dp (
      .clock(clock), .ctrl(ctrl), .digit(lo_dig[DIGITS]), .total(lo_total)
   );
   rdst_digit_dp u_hi_dp (
      .clock(clock), .ctrl(ctrl), .digit(hi_dig[DIGITS]), .total(hi_total)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid) state_in = ST_CONV;
         ST_CONV: if (cnt_ff == CntW'(BinW - 1)) state_in = ST_WALK;
         ST_WALK: if (cnt_ff == CntW'(DIGITS - 1)) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      accept       = (state_ff == ST_IDLE) && req.valid;
      load_rsp     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
      ctrl.clear   = accept;
      ctrl.conv    = (state_ff == ST_CONV);
      ctrl.walk    = (state_ff == ST_WALK);
      cnt_in       = cnt_ff;
      lo_bin_in    = lo_bin_ff;
      hi_bin_in    = hi_bin_ff;
      lo_zero_in   = lo_zero_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_tot_in   = rsp_tot_ff;
      rsp_err_in   = rsp_err_ff;
      if (accept) begin
         cnt_in     = '0;
         lo_zero_in = (lo_sat == '0);
         lo_bin_in  = (lo_sat == '0) ? '0 : lo_sat - BinW'(1);
         hi_bin_in  = hi_sat;
         err_in     = req.lower_bound > req.upper_bound;
      end else if (ctrl.conv) begin
         cnt_in    = (cnt_ff == CntW'(BinW - 1)) ? '0 : cnt_ff + CntW'(1);
         lo_bin_in = {lo_bin_ff[BinW-2:0], 1'b0};
         hi_bin_in = {hi_bin_ff[BinW-2:0], 1'b0};
      end else if (ctrl.walk) begin
         cnt_in = cnt_ff + CntW'(1);
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = err_ff;
         rsp_tot_in   = err_ff ? '0 : hi_total - (lo_zero_ff ? '0 : lo_total);
      end
   end

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.digit_sum_total = rsp_tot_ff;
   assign rsp.range_error     = rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_bin_ff  <= lo_bin_in;
      hi_bin_ff  <= hi_bin_in;
      lo_zero_ff <= lo_zero_in;
      err_ff     <= err_in;
      rsp_tot_ff <= rsp_tot_in;
      rsp_err_ff <= rsp_err_in;
   end

   a_accept_conv: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff == ST_CONV)
      else $error("transfer did not start conversion");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.range_error |-> rsp.digit_sum_total == '0)
      else $error("error result carries nonzero total");
   a_walk_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> cnt_ff < CntW'(DIGITS))
      else $error("digit walk overran");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && (!rsp.valid || rsp.ready) |=> rsp.valid)
      else $error("result not loaded");

endmodule

/* test/rdst_scoreboard.sv */
// ----------------------------------------------------------------------------
// rdst_scoreboard
// predicts the digit-sum total of each accepted query and checks the results
// in order against the expected queue
// ----------------------------------------------------------------------------
package rdst_tb_pkg;

   import rdst_pkg::*;

   localparam int NumDigits = 16;

   typedef struct packed {
      logic [TotW-1:0] digit_sum_total;
      logic            range_error;
   } range_total_type;

   class range_total_board;
      range_total_type totals_due[$];
      int              mismatches;
      int              checked;
      int              reversed;

      function logic [63:0] largest_bound();
         logic [63:0] p;
         p = 64'd1;
         for (int i = 0; i < NumDigits; i++) begin
            p = p * 64'd10;
         end
         return p - 64'd1;
      endfunction

      function logic [63:0] prefix_total(input logic [63:0] n);
         logic [3:0]  dig[NumDigits];
         logic [63:0] t_cnt, t_tot, f_cnt, f_tot, nf_cnt, nf_tot, d;
         t_cnt = 64'd1;
         t_tot = 64'd0;
         f_cnt = 64'd0;
         f_tot = 64'd0;
         for (int i = NumDigits - 1; i >= 0; i--) begin
            dig[i] = 4'(n % 64'd10);
            n = n / 64'd10;
         end
         for (int i = 0; i < NumDigits; i++) begin
            d = 64'(dig[i]);
            nf_cnt = 64'd10 * f_cnt + d * t_cnt;
            nf_tot = 64'd10 * f_tot + 64'd45 * f_cnt + d * t_tot
                     + ((d * (d - ((d != 0) ? 64'd1 : 64'd0))) / 64'd2) * t_cnt;
            t_tot = t_tot + d * t_cnt;
            f_cnt = nf_cnt;
            f_tot = nf_tot;
         end
         return f_tot + t_tot;
      endfunction

      function void note_query(input logic [BinW-1:0] lo_in,
                               input logic [BinW-1:0] hi_in);
         range_total_type r;
         logic [63:0]     lo, hi, top, sum;
         lo = 64'(lo_in);
         hi = 64'(hi_in);
         top = largest_bound();
         if (lo > hi) begin
            r.digit_sum_total = '0;
            r.range_error = 1'b1;
            reversed++;
         end else begin
            if (lo > top) lo = top;
            if (hi > top) hi = top;
            sum = prefix_total(hi);
            if (lo != 0) sum = sum - prefix_total(lo - 64'd1);
            r.digit_sum_total = sum[TotW-1:0];
            r.range_error = 1'b0;
         end
         totals_due = {totals_due, r};
      endfunction

      task report(input string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endtask

      task check_total(input logic [TotW-1:0] total, input logic err);
         range_total_type e;
         checked++;
         if (totals_due.size() == 0) begin
            report($sformatf("result %0d with nothing expected", checked));
            return;
         end
         e = totals_due.pop_front();
         if (total !== e.digit_sum_total) begin
            report($sformatf("result %0d total %0d, expected %0d", checked, total,
                             e.digit_sum_total));
         end
         if (err !== e.range_error) begin
            report($sformatf("result %0d range_error %0b, expected %0b", checked, err,
                             e.range_error));
         end
      endtask
   endclass

endpackage

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// drives range queries with random bursts and result stalls, including a
// long result hold-off and a full drain, and checks every digit-sum total
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rdst_pkg::*;
   import rdst_tb_pkg::*;

   localparam int NumRandom  = 1600;
   localparam int StallLimit = 20000;
   localparam logic [BinW-1:0] TopBound = 54'd9999999999999999;
   localparam logic [BinW-1:0] AllOnes  = {BinW{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   rdst_req_if req ();
   rdst_rsp_if rsp ();

   range_digit_sum_total dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   range_total_board board = new();
   int  sent = 0;
   int  idle_cycles = 0;
   bit  hold_off = 1'b0;
   bit  done = 1'b0;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         board.note_query(req.lower_bound, req.upper_bound);
         sent++;
      end
      if (!reset && rsp.valid && rsp.ready)
         board.check_total(rsp.digit_sum_total, rsp.range_error);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= StallLimit && !done) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      int phase;
      phase = $urandom_range(0, 15);
      if (reset || hold_off)
         rsp.ready <= 1'b0;
      else if (phase < 4 && sent > 100)
         rsp.ready <= 1'b0;
      else
         rsp.ready <= 1'b1;
   end

   task automatic send_query(input logic [BinW-1:0] lo, input logic [BinW-1:0] hi);
      req.valid <= 1'b1;
      req.lower_bound <= lo;
      req.upper_bound <= hi;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic [BinW-1:0] pick_bound();
      logic [BinW-1:0] v;
      case ($urandom_range(0, 5))
         0: v = 54'($urandom_range(0, 1000));
         1: v = 54'({$urandom, $urandom}) % (TopBound + 1);
         2: v = 54'({$urandom, $urandom});
         3: v = TopBound - 54'($urandom_range(0, 50));
         4: v = 54'($urandom) % 54'(1 << $urandom_range(1, 30));
         default: v = 54'({$urandom, $urandom}) % 54'd100000000;
      endcase
      return v;
   endfunction

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (board.totals_due.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [BinW-1:0] a, b;
      req.valid = 1'b0;
      req.lower_bound = '0;
      req.upper_bound = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_query('0, '0);
      send_query('0, 54'd9);
      send_query(54'd1, 54'd9);
      send_query(54'd10, 54'd19);
      send_query(54'd0, 54'd99);
      send_query(54'd5, 54'd4);
      send_query(AllOnes, '0);
      send_query('0, TopBound);
      send_query(TopBound, TopBound);
      send_query('0, AllOnes);
      send_query(AllOnes, AllOnes);
      send_query(TopBound + 1, AllOnes);
      send_query(54'd999, 54'd1000);
      send_query(54'd12345, 54'd678901);
      send_query(TopBound - 1, TopBound + 5);
      send_query(54'h2AAAAAAAAAAAAA, 54'h15555555555555);
      send_query(54'h15555555555555, 54'h2AAAAAAAAAAAAA);
      wait_drained();

      // long receiver hold-off while queries keep coming
      hold_off = 1'b1;
      fork
         begin
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end
         repeat (6) send_query(pick_bound(), pick_bound());
      join
      wait_drained();

      for (int i = 0; i < NumRandom; ) begin
         int burst;
         burst = $urandom_range(1, 12);
         for (int j = 0; j < burst && i < NumRandom; j++, i++) begin
            a = pick_bound();
            b = pick_bound();
            if ($urandom_range(0, 9) < 8 && a > b) begin
               send_query(b, a);
            end else begin
               send_query(a, b);
            end
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 80));
         if (i % 400 == 0) wait_drained();
      end
      wait_drained();
      repeat (100) @(negedge clock);
      done = 1'b1;

      $display("ran %0d queries, %0d checked, %0d reversed ranges", sent,
               board.checked, board.reversed);
      if (board.mismatches == 0 && board.totals_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.totals_due.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
